// ===== sv/lvb_pkg.sv =====
// Shared widths, constants and types for the look-at view basis pipeline.
// Depends on nothing; every other file of the block refers to it by scoped names.

package lvb_pkg;

   // Input coordinate width, Q16.16 two's complement
   localparam int CoordWidth = 32;
   // Difference target - camera never wraps at one extra bit
   localparam int DiffWidth = CoordWidth + 1;
   // Result axes are Q1.30 in 32 bits
   localparam int AxisWidth = 32;
   localparam int FracBits = 30;
   localparam logic [AxisWidth-2:0] OneQ30 = (AxisWidth-1)'(1) << FracBits;

   // Normaliser internals
   localparam int PosWidth = $clog2(DiffWidth);
   localparam int ScaledWidth = FracBits;                  // magnitudes below 2^30; largest in [2^29, 2^30) if nonzero
   localparam int ScaledTop = ScaledWidth - 1;             // target leading-one position
   localparam int SquareWidth = 2 * ScaledWidth + 2;       // sum of three squares
   localparam int RootWidth = SquareWidth / 2;             // floor square root
   localparam int SqrtSteps = RootWidth;
   localparam int SqrtRemWidth = RootWidth + 2;
   localparam int QuotWidth = RootWidth;
   localparam int DivSteps = QuotWidth;
   localparam int DividendWidth = ScaledWidth + FracBits + 1;
   localparam int ProdWidth = 2 * AxisWidth;

   // Stream payload widths
   localparam int ReqDataWidth = ((6 * CoordWidth + 7) / 8) * 8;
   localparam int RspDataWidth = ((9 * AxisWidth + 7) / 8) * 8;

   typedef struct packed {
      logic valid;
      logic degen;
   } ctl_type;

   typedef logic [2:0][DiffWidth-1:0] diff_vec_type;
   typedef logic [2:0][AxisWidth-1:0] axis_vec_type;

endpackage

// ===== sv/lvb_norm.sv =====
// Pipelined three-component normaliser: scale, sum of squares, bit-serial square
// root and per-lane restoring division, one stage per root or quotient bit. Uses lvb_pkg.

module lvb_norm (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  lvb_pkg::ctl_type      ctl_in,
   input  lvb_pkg::diff_vec_type vec_in,
   output lvb_pkg::ctl_type      ctl_out,
   output lvb_pkg::axis_vec_type axis_out
);

   localparam int DW = lvb_pkg::DiffWidth;
   localparam int SW = lvb_pkg::ScaledWidth;
   localparam int QW = lvb_pkg::QuotWidth;
   localparam int RW = lvb_pkg::RootWidth;
   localparam int XW = lvb_pkg::SquareWidth;
   localparam int NW = lvb_pkg::DividendWidth;
   localparam int AW = lvb_pkg::AxisWidth;

   // stage A: sign and magnitude
   lvb_pkg::ctl_type      ctl_a_ff;
   logic [2:0]            neg_a_ff;
   logic [2:0][DW-1:0]    mag_a_ff;
   // stage B: leading-one position of the largest magnitude
   lvb_pkg::ctl_type      ctl_b_ff;
   logic [2:0]            neg_b_ff;
   logic [2:0][DW-1:0]    mag_b_ff;
   logic [lvb_pkg::PosWidth-1:0] pos_b_ff, pos_b_in;
   // stage C: scaled magnitudes
   lvb_pkg::ctl_type      ctl_c_ff;
   logic [2:0]            neg_c_ff;
   logic [2:0][SW-1:0]    sm_c_ff, sm_c_in;
   // stage D: squares
   lvb_pkg::ctl_type      ctl_d_ff;
   logic [2:0]            neg_d_ff;
   logic [2:0][SW-1:0]    sm_d_ff;
   logic [2:0][2*SW-1:0]  sq_d_ff;
   // stage E: length squared
   lvb_pkg::ctl_type      ctl_e_ff;
   logic [2:0]            neg_e_ff;
   logic [2:0][SW-1:0]    sm_e_ff;
   logic [XW-1:0]         len2_e_ff;
   // square root steps
   lvb_pkg::ctl_type      sq_ctl_ff  [lvb_pkg::SqrtSteps];
   logic [2:0]            sq_neg_ff  [lvb_pkg::SqrtSteps];
   logic [2:0][SW-1:0]    sq_sm_ff   [lvb_pkg::SqrtSteps];
   logic [lvb_pkg::SqrtRemWidth-1:0] sq_rem_ff [lvb_pkg::SqrtSteps];
   logic [RW-1:0]         sq_root_ff [lvb_pkg::SqrtSteps];
   logic [XW-1:0]         sq_x_ff    [lvb_pkg::SqrtSteps];
   // stage F: dividends
   lvb_pkg::ctl_type      ctl_f_ff;
   logic [2:0]            neg_f_ff;
   logic [RW-1:0]         len_f_ff;
   logic [2:0][NW-1:0]    num_f_ff;
   // division steps
   lvb_pkg::ctl_type      dv_ctl_ff  [lvb_pkg::DivSteps];
   logic [2:0]            dv_neg_ff  [lvb_pkg::DivSteps];
   logic [RW-1:0]         dv_len_ff  [lvb_pkg::DivSteps];
   logic [2:0][NW-1:0]    dv_num_ff  [lvb_pkg::DivSteps];
   logic [2:0][QW-1:0]    dv_rem_ff  [lvb_pkg::DivSteps];
   logic [2:0][QW-1:0]    dv_quot_ff [lvb_pkg::DivSteps];
   // stage G: cap and sign
   lvb_pkg::ctl_type      ctl_g_ff;
   lvb_pkg::axis_vec_type axis_g_ff, axis_g_in;

   logic [DW-1:0] any_mag;

   always_comb begin
      any_mag = mag_a_ff[0] | mag_a_ff[1] | mag_a_ff[2];
      pos_b_in = '0;
      for (int i = 0; i < DW; i++) begin
         if (any_mag[i]) pos_b_in = lvb_pkg::PosWidth'(i);
      end
   end

   always_comb begin
      logic [DW+SW-2:0] wide;
      for (int l = 0; l < 3; l++) begin
         wide = {mag_b_ff[l], {(SW-1){1'b0}}} >> pos_b_ff;
         sm_c_in[l] = wide[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff <= '0;
         ctl_b_ff <= '0;
         ctl_c_ff <= '0;
         ctl_d_ff <= '0;
         ctl_e_ff <= '0;
         ctl_f_ff <= '0;
         ctl_g_ff <= '0;
      end else if (en) begin
         ctl_a_ff <= ctl_in;
         ctl_b_ff <= ctl_a_ff;
         ctl_c_ff <= ctl_b_ff;
         ctl_d_ff <= ctl_c_ff;
         ctl_e_ff <= ctl_d_ff;
         ctl_f_ff <= sq_ctl_ff[lvb_pkg::SqrtSteps-1];
         ctl_g_ff <= dv_ctl_ff[lvb_pkg::DivSteps-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < 3; l++) begin
            neg_a_ff[l] <= vec_in[l][DW-1];
            mag_a_ff[l] <= vec_in[l][DW-1] ? DW'(0) - vec_in[l] : vec_in[l];
            sq_d_ff[l]  <= (2*SW)'(sm_c_ff[l]) * (2*SW)'(sm_c_ff[l]);
            num_f_ff[l] <= {1'b0, sq_sm_ff[lvb_pkg::SqrtSteps-1][l],
                            {lvb_pkg::FracBits{1'b0}}}
                           + NW'(sq_root_ff[lvb_pkg::SqrtSteps-1] >> 1);
         end
         neg_b_ff  <= neg_a_ff;
         mag_b_ff  <= mag_a_ff;
         pos_b_ff  <= pos_b_in;
         neg_c_ff  <= neg_b_ff;
         sm_c_ff   <= sm_c_in;
         neg_d_ff  <= neg_c_ff;
         sm_d_ff   <= sm_c_ff;
         neg_e_ff  <= neg_d_ff;
         sm_e_ff   <= sm_d_ff;
         len2_e_ff <= XW'(sq_d_ff[0]) + XW'(sq_d_ff[1]) + XW'(sq_d_ff[2]);
         neg_f_ff  <= sq_neg_ff[lvb_pkg::SqrtSteps-1];
         len_f_ff  <= sq_root_ff[lvb_pkg::SqrtSteps-1];
         axis_g_ff <= axis_g_in;
      end
   end

   // square root: one root bit per stage
   for (genvar j = 0; j < lvb_pkg::SqrtSteps; j++) begin : g_sqrt
      lvb_pkg::ctl_type                 ctl_src;
      logic [2:0]                       neg_src;
      logic [2:0][SW-1:0]               sm_src;
      logic [lvb_pkg::SqrtRemWidth-1:0] rem_src;
      logic [RW-1:0]                    root_src;
      logic [XW-1:0]                    x_src;
      logic [lvb_pkg::SqrtRemWidth+1:0] trial_rem, trial_sub, trial_diff;

      if (j == 0) begin : g_first
         assign ctl_src  = ctl_e_ff;
         assign neg_src  = neg_e_ff;
         assign sm_src   = sm_e_ff;
         assign rem_src  = '0;
         assign root_src = '0;
         assign x_src    = len2_e_ff;
      end else begin : g_next
         assign ctl_src  = sq_ctl_ff[j-1];
         assign neg_src  = sq_neg_ff[j-1];
         assign sm_src   = sq_sm_ff[j-1];
         assign rem_src  = sq_rem_ff[j-1];
         assign root_src = sq_root_ff[j-1];
         assign x_src    = sq_x_ff[j-1];
      end

      assign trial_rem  = {rem_src, x_src[XW-1 -: 2]};
      assign trial_sub  = {2'b00, root_src, 2'b01};
      assign trial_diff = trial_rem - trial_sub;

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_ctl_ff[j] <= '0;
         end else if (en) begin
            sq_ctl_ff[j] <= ctl_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sq_neg_ff[j] <= neg_src;
            sq_sm_ff[j]  <= sm_src;
            sq_x_ff[j]   <= {x_src[XW-3:0], 2'b00};
            if (trial_rem >= trial_sub) begin
               sq_rem_ff[j]  <= trial_diff[lvb_pkg::SqrtRemWidth-1:0];
               sq_root_ff[j] <= {root_src[RW-2:0], 1'b1};
            end else begin
               sq_rem_ff[j]  <= trial_rem[lvb_pkg::SqrtRemWidth-1:0];
               sq_root_ff[j] <= {root_src[RW-2:0], 1'b0};
            end
         end
      end
   end

   // division: one quotient bit per stage, three lanes side by side
   for (genvar k = 0; k < lvb_pkg::DivSteps; k++) begin : g_div
      lvb_pkg::ctl_type   ctl_src;
      logic [2:0]         neg_src;
      logic [RW-1:0]      len_src;
      logic [2:0][NW-1:0] num_src;
      logic [2:0][QW-1:0] rem_src, quot_src, rem_in, quot_in;

      if (k == 0) begin : g_first
         assign ctl_src = ctl_f_ff;
         assign neg_src = neg_f_ff;
         assign len_src = len_f_ff;
         assign num_src = num_f_ff;
         always_comb begin
            for (int l = 0; l < 3; l++) begin
               rem_src[l]  = QW'(num_f_ff[l][NW-1:QW]);
               quot_src[l] = '0;
            end
         end
      end else begin : g_next
         assign ctl_src  = dv_ctl_ff[k-1];
         assign neg_src  = dv_neg_ff[k-1];
         assign len_src  = dv_len_ff[k-1];
         assign num_src  = dv_num_ff[k-1];
         assign rem_src  = dv_rem_ff[k-1];
         assign quot_src = dv_quot_ff[k-1];
      end

      always_comb begin
         logic [QW:0] trial;
         for (int l = 0; l < 3; l++) begin
            trial = {rem_src[l], num_src[l][QW-1-k]};
            if (trial >= {1'b0, len_src}) begin
               rem_in[l]  = QW'(trial - {1'b0, len_src});
               quot_in[l] = {quot_src[l][QW-2:0], 1'b1};
            end else begin
               rem_in[l]  = trial[QW-1:0];
               quot_in[l] = {quot_src[l][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ctl_ff[k] <= '0;
         end else if (en) begin
            dv_ctl_ff[k] <= ctl_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_neg_ff[k]  <= neg_src;
            dv_len_ff[k]  <= len_src;
            dv_num_ff[k]  <= num_src;
            dv_rem_ff[k]  <= rem_in;
            dv_quot_ff[k] <= quot_in;
         end
      end
   end

   // cap at one and restore the sign
   always_comb begin
      logic [2:0][QW-1:0] q;
      logic [AW-1:0]      capped;
      q = dv_quot_ff[lvb_pkg::DivSteps-1];
      for (int l = 0; l < 3; l++) begin
         capped = (q[l] > QW'(lvb_pkg::OneQ30)) ? AW'(lvb_pkg::OneQ30) : AW'(q[l]);
         axis_g_in[l] = dv_neg_ff[lvb_pkg::DivSteps-1][l] ? AW'(0) - capped : capped;
      end
   end

   assign ctl_out  = ctl_g_ff;
   assign axis_out = axis_g_ff;

endmodule

// ===== sv/lvb_cross.sv =====
// Up axis as forward cross side with Q1.30 rounding, plus the zeroing of degenerate
// results. Three register stages; uses lvb_pkg.

module lvb_cross (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  lvb_pkg::ctl_type      ctl_in,
   input  lvb_pkg::axis_vec_type fwd_in,
   input  lvb_pkg::axis_vec_type side_in,
   output lvb_pkg::ctl_type      ctl_out,
   output lvb_pkg::axis_vec_type fwd_out,
   output lvb_pkg::axis_vec_type side_out,
   output lvb_pkg::axis_vec_type up_out
);

   localparam int PW = lvb_pkg::ProdWidth;
   localparam int AW = lvb_pkg::AxisWidth;

   lvb_pkg::ctl_type      ctl_p_ff, ctl_u_ff, ctl_o_ff;
   lvb_pkg::axis_vec_type fwd_p_ff, side_p_ff, fwd_u_ff, side_u_ff;
   lvb_pkg::axis_vec_type fwd_o_ff, side_o_ff, up_o_ff, up_o_in;
   logic signed [PW-1:0]  prod_ff [4];
   logic [2:0][PW:0]      up_u_ff, up_u_in;

   // side y is zero except for degenerate items, which are zeroed, so each up component needs at most two products
   always_comb begin
      up_u_in[0] = (PW+1)'(prod_ff[0]);
      up_u_in[1] = (PW+1)'(prod_ff[1]) - (PW+1)'(prod_ff[2]);
      up_u_in[2] = (PW+1)'(0) - (PW+1)'(prod_ff[3]);
   end

   always_comb begin
      logic          neg;
      logic [PW:0]   mag, rnd;
      logic [AW-1:0] q;
      for (int l = 0; l < 3; l++) begin
         neg = up_u_ff[l][PW];
         mag = neg ? (PW+1)'(0) - up_u_ff[l] : up_u_ff[l];
         rnd = (mag + ((PW+1)'(1) << (lvb_pkg::FracBits - 1))) >> lvb_pkg::FracBits;
         q   = (rnd > (PW+1)'(lvb_pkg::OneQ30)) ? AW'(lvb_pkg::OneQ30) : rnd[AW-1:0];
         up_o_in[l] = neg ? AW'(0) - q : q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_p_ff <= '0;
         ctl_u_ff <= '0;
         ctl_o_ff <= '0;
      end else if (en) begin
         ctl_p_ff <= ctl_in;
         ctl_u_ff <= ctl_p_ff;
         ctl_o_ff <= ctl_u_ff;
      end
   end

   // widen both factors before multiplying so the full product is kept
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff[0] <= PW'($signed(fwd_in[1])) * PW'($signed(side_in[2]));
         prod_ff[1] <= PW'($signed(fwd_in[2])) * PW'($signed(side_in[0]));
         prod_ff[2] <= PW'($signed(fwd_in[0])) * PW'($signed(side_in[2]));
         prod_ff[3] <= PW'($signed(fwd_in[1])) * PW'($signed(side_in[0]));
         fwd_p_ff   <= fwd_in;
         side_p_ff  <= side_in;
         up_u_ff    <= up_u_in;
         fwd_u_ff   <= fwd_p_ff;
         side_u_ff  <= side_p_ff;
         // drop every axis of a degenerate item
         fwd_o_ff   <= ctl_u_ff.degen ? '0 : fwd_u_ff;
         side_o_ff  <= ctl_u_ff.degen ? '0 : side_u_ff;
         up_o_ff    <= ctl_u_ff.degen ? '0 : up_o_in;
      end
   end

   assign ctl_out  = ctl_o_ff;
   assign fwd_out  = fwd_o_ff;
   assign side_out = side_o_ff;
   assign up_out   = up_o_ff;

endmodule

// ===== sv/look_at_view_basis.sv =====
// Top level of the look-at view basis pipeline: difference stage, two normalisers
// and the cross-product stage. Depends on lvb_pkg, lvb_norm and lvb_cross.
//
//   channel   direction   tdata (lowest bits first)                        tuser
//   req_      in          cam_x, cam_y, cam_z, target_x, target_y, target_z  -
//   rsp_      out         side_xyz, upward_xyz, forward_xyz                  degenerate
//
// One transfer per cycle in each direction while rsp_tready is high.
// Stages in order: one difference stage, the two normalisers side by side (31 square-root
// steps and 31 division steps each, one bit per stage), then the cross-product stage.
// Reset clears only the valid and degen bits of the pipeline; payload keeps garbage.
// A stall freezes the whole pipeline while the output register holds a result that
// is not taken; req_tready then drops in the same cycle.

module look_at_view_basis (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // cam_x, cam_y, cam_z, target_x, target_y, target_z
   input  logic [lvb_pkg::ReqDataWidth-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // side_x, side_y, side_z, upward_x, upward_y, upward_z, forward_x, forward_y, forward_z
   output logic [lvb_pkg::RspDataWidth-1:0] rsp_tdata,
   // degenerate
   output logic                             rsp_tuser
);

   localparam int CW = lvb_pkg::CoordWidth;
   localparam int DW = lvb_pkg::DiffWidth;

   logic                  en;
   lvb_pkg::ctl_type      ctl_d_ff, ctl_d_in;
   lvb_pkg::diff_vec_type fwd_d_ff, side_d_ff, fwd_d_in, side_d_in;
   lvb_pkg::ctl_type      fwd_ctl, side_ctl, cross_ctl_in, out_ctl;
   lvb_pkg::axis_vec_type fwd_axis, side_axis, fwd_out, side_out, up_out;

   // advance everything unless a finished result is waiting
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // d = target - cam at one extra bit, so it never wraps
   always_comb begin
      logic [CW-1:0] cam, tgt;
      for (int l = 0; l < 3; l++) begin
         cam = req_tdata[l*CW +: CW];
         tgt = req_tdata[(l+3)*CW +: CW];
         fwd_d_in[l] = {tgt[CW-1], tgt} - {cam[CW-1], cam};
      end
      // side = up x d = (dz, 0, -dx)
      side_d_in[0] = fwd_d_in[2];
      side_d_in[1] = '0;
      side_d_in[2] = DW'(0) - fwd_d_in[0];
      ctl_d_in.valid = req_tvalid;
      ctl_d_in.degen = (fwd_d_in[0] == '0) && (fwd_d_in[2] == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_d_ff <= '0;
      end else if (en) begin
         ctl_d_ff <= ctl_d_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fwd_d_ff  <= fwd_d_in;
         side_d_ff <= side_d_in;
      end
   end

   lvb_norm u_norm_fwd (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .ctl_in   (ctl_d_ff),
      .vec_in   (fwd_d_ff),
      .ctl_out  (fwd_ctl),
      .axis_out (fwd_axis)
   );

   lvb_norm u_norm_side (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .ctl_in   (ctl_d_ff),
      .vec_in   (side_d_ff),
      .ctl_out  (side_ctl),
      .axis_out (side_axis)
   );

   // both normalisers run in lock step
   assign cross_ctl_in.valid = fwd_ctl.valid && side_ctl.valid;
   assign cross_ctl_in.degen = fwd_ctl.degen || side_ctl.degen;

   lvb_cross u_cross (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .ctl_in   (cross_ctl_in),
      .fwd_in   (fwd_axis),
      .side_in  (side_axis),
      .ctl_out  (out_ctl),
      .fwd_out  (fwd_out),
      .side_out (side_out),
      .up_out   (up_out)
   );

   assign rsp_tvalid = out_ctl.valid;
   assign rsp_tuser  = out_ctl.degen;
   assign rsp_tdata  = lvb_pkg::RspDataWidth'({fwd_out[2], fwd_out[1], fwd_out[0],
                                               up_out[2], up_out[1], up_out[0],
                                               side_out[2], side_out[1], side_out[0]});

endmodule
